### sv/pts_pkg.sv
package pts_pkg;

   localparam int MaxTasks       = 16;
   localparam int NumEvents      = 16;
   localparam int PriorityLevels = 8;
   localparam int SlotW          = 4;
   localparam int CntW           = 5;

   typedef enum logic [2:0] {
      ACT_SPAWN      = 3'd0,
      ACT_TICK       = 3'd1,
      ACT_WAIT_DELAY = 3'd2,
      ACT_WAIT_EVENT = 3'd3,
      ACT_YIELD      = 3'd4,
      ACT_FINISH     = 3'd5,
      ACT_CANCEL     = 3'd6,
      ACT_SIGNAL     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_READY      = 2'd0,
      ST_WAIT_DELAY = 2'd1,
      ST_WAIT_EVENT = 2'd2,
      ST_DONE       = 2'd3
   } task_state_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_POOL_FULL = 2'd1,
      STAT_TOO_LARGE = 2'd2,
      STAT_TABLE_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WAKE,
      SEQ_PICK,
      SEQ_REAP,
      SEQ_SPAWN,
      SEQ_DONE
   } seq_state_type;

   // The first member is the most significant, so action lands in the lowest bits.
   typedef struct packed {
      logic [3:0]        event_id;
      logic [31:0]       delay;
      logic [31:0]       time_now;
      logic [1:0]        alloc_status;
      logic [2:0]        priority_req;
      logic [SlotW-1:0]  task_id;
      action_type        action;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [3:0]        slot_id;
      logic              chosen_valid;
      logic              keep_running;
      logic              cancel_seen;
   } rsp_type;

endpackage

### sv/pts_ram.sv
module pts_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### sv/priority_task_scheduler.sv
// Fixed-priority cooperative task scheduler.
// Items enter on the req_ channel (tvalid/tready/tdata) and each gives one
// item on the rsp_ channel. req_tready is high only while the sequencer is
// idle; one item is worked at a time.
// A tick walks the sixteen slots three times through one shared slot unit:
// a wake pass, a pick pass and a reap pass, each one slot per cycle, with the
// wake-time memory read for a slot requested in the cycle before it. A spawn
// walks the slots one per cycle until it finds a free one; a spawn with a
// failing allocation reports its status without walking the slots, and every
// other action and a halted tick go straight to the result. The result sits
// in an output register until rsp_tready takes it; while it waits no new item
// is accepted. The next item is accepted the cycle after the result is taken.
// The csr_ channel writes the halted bit; csr_tready is always high. While
// halted, a tick changes nothing and reports not running.
// Reset clears slot occupancy, cancel flags, pending events and halted.
// Task state, priority, wake time and awaited event are undefined until a
// spawn or wait writes them.
module priority_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], task_id[6:3], priority_req[9:7], alloc_status[11:10],
   // time_now[43:12], delay[75:44], event_id[79:76]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], slot_id[5:2], chosen_valid[6], keep_running[7],
   // cancel_seen[8], zero fill[15:9]
   output logic [15:0] rsp_tdata,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic        csr_tdata
);
   localparam int N = pts_pkg::MaxTasks;
   localparam int W = pts_pkg::SlotW;

   pts_pkg::seq_state_type state_ff, state_in;
   pts_pkg::req_type       req_ff, req_in;
   pts_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   halted_ff;
   logic [pts_pkg::CntW-1:0] idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [2:0]             best_ff, best_in;
   logic [W-1:0]           chosen_ff, chosen_in;
   logic                   any_ff, any_in;

   logic [N-1:0]           used_ff, used_in;
   logic [N-1:0]           creq_ff, creq_in;
   logic [N-1:0]           cobs_ff, cobs_in;
   logic [pts_pkg::NumEvents-1:0] evp_ff, evp_in;
   pts_pkg::task_state_type tstate_ff [N];
   pts_pkg::task_state_type tstate_in [N];
   logic [2:0]             prio_ff [N];
   logic [2:0]             prio_in [N];
   logic [3:0]             aev_ff [N];
   logic [3:0]             aev_in [N];

   logic                   wt_we;
   logic [W-1:0]           wt_waddr, wt_raddr;
   logic [31:0]            wt_wdata, wt_rdata;

   logic [W-1:0]           cur;
   logic [W-1:0]           rid;
   logic                   canc, fired;
   logic [2:0]             sprio;

   pts_ram #(.Width(32), .Depth(N)) u_wake (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(wt_wdata),
      .rd_addr(wt_raddr), .rd_data(wt_rdata)
   );

   assign req_tready = (state_ff == pts_pkg::SEQ_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.cancel_seen, rsp_ff.keep_running,
                        rsp_ff.chosen_valid, rsp_ff.slot_id, rsp_ff.status};
   assign csr_tready = 1'b1;

   assign cur   = idx_ff[W-1:0];
   assign rid   = req_ff.task_id;
   assign sprio = (req_ff.priority_req >= 3'(pts_pkg::PriorityLevels - 1))
                  ? 3'(pts_pkg::PriorityLevels - 1) : req_ff.priority_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pts_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         halted_ff    <= 1'b0;
         used_ff      <= '0;
         creq_ff      <= '0;
         cobs_ff      <= '0;
         evp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         creq_ff      <= creq_in;
         cobs_ff      <= cobs_in;
         evp_ff       <= evp_in;
         if (csr_tvalid) begin
            halted_ff <= csr_tdata;
         end
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      chosen_ff <= chosen_in;
      any_ff    <= any_in;
      tstate_ff <= tstate_in;
      prio_ff   <= prio_in;
      aev_ff    <= aev_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      chosen_in    = chosen_ff;
      any_in       = any_ff;
      used_in      = used_ff;
      creq_in      = creq_ff;
      cobs_in      = cobs_ff;
      evp_in       = evp_ff;
      tstate_in    = tstate_ff;
      prio_in      = prio_ff;
      aev_in       = aev_ff;
      wt_we        = 1'b0;
      wt_waddr     = rid;
      wt_wdata     = req_ff.time_now + req_ff.delay;
      wt_raddr     = cur;
      canc         = creq_ff[cur];
      fired        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pts_pkg::SEQ_IDLE: begin
            wt_raddr = '0;
            if (req_tvalid && req_tready) begin
               req_in    = pts_pkg::req_type'(req_tdata);
               rsp_in    = '0;
               idx_in    = '0;
               found_in  = 1'b0;
               best_in   = '0;
               chosen_in = '0;
               any_in    = 1'b0;
               state_in  = pts_pkg::SEQ_DONE;
               if (req_in.action == pts_pkg::ACT_TICK) begin
                  state_in = halted_ff ? pts_pkg::SEQ_DONE : pts_pkg::SEQ_WAKE;
               end else if (req_in.action == pts_pkg::ACT_SPAWN) begin
                  state_in = pts_pkg::SEQ_SPAWN;
               end
            end
         end
         pts_pkg::SEQ_WAKE: begin
            // The read data for this slot was requested in the previous cycle.
            wt_raddr = W'(idx_ff + 1'b1);
            if (used_ff[cur]) begin
               if (tstate_ff[cur] == pts_pkg::ST_WAIT_DELAY) begin
                  if (canc) cobs_in[cur] = 1'b1;
                  if (!(req_ff.time_now < wt_rdata) || canc) begin
                     tstate_in[cur] = pts_pkg::ST_READY;
                  end
               end else if (tstate_ff[cur] == pts_pkg::ST_WAIT_EVENT) begin
                  if (evp_ff[aev_ff[cur]]) begin
                     evp_in[aev_ff[cur]] = 1'b0;
                     fired = 1'b1;
                  end
                  if (canc) cobs_in[cur] = 1'b1;
                  if (fired || canc) tstate_in[cur] = pts_pkg::ST_READY;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == pts_pkg::CntW'(N - 1)) begin
               idx_in   = '0;
               state_in = pts_pkg::SEQ_PICK;
            end
         end
         pts_pkg::SEQ_PICK: begin
            if (used_ff[cur]) begin
               any_in = 1'b1;
               if (tstate_ff[cur] == pts_pkg::ST_READY &&
                   (!found_ff || prio_ff[cur] < best_ff)) begin
                  found_in  = 1'b1;
                  best_in   = prio_ff[cur];
                  chosen_in = cur;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == pts_pkg::CntW'(N - 1)) begin
               idx_in   = '0;
               state_in = pts_pkg::SEQ_REAP;
            end
         end
         pts_pkg::SEQ_REAP: begin
            if (used_ff[cur] && tstate_ff[cur] == pts_pkg::ST_DONE) begin
               used_in[cur] = 1'b0;
               creq_in[cur] = 1'b0;
               cobs_in[cur] = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == pts_pkg::CntW'(N - 1)) begin
               rsp_in.chosen_valid = found_ff;
               rsp_in.keep_running = found_ff || any_ff;
               rsp_in.slot_id      = found_ff ? chosen_ff : '0;
               rsp_in.cancel_seen  = found_ff && cobs_ff[chosen_ff];
               state_in            = pts_pkg::SEQ_DONE;
            end
         end
         pts_pkg::SEQ_SPAWN: begin
            if (req_ff.alloc_status == pts_pkg::STAT_TOO_LARGE) begin
               rsp_in.status = pts_pkg::STAT_TOO_LARGE;
               state_in      = pts_pkg::SEQ_DONE;
            end else if (req_ff.alloc_status != pts_pkg::STAT_OK) begin
               rsp_in.status = pts_pkg::STAT_POOL_FULL;
               state_in      = pts_pkg::SEQ_DONE;
            end else if (idx_ff == pts_pkg::CntW'(N)) begin
               rsp_in.status = pts_pkg::STAT_TABLE_FULL;
               state_in      = pts_pkg::SEQ_DONE;
            end else if (!used_ff[cur]) begin
               used_in[cur]   = 1'b1;
               tstate_in[cur] = pts_pkg::ST_READY;
               prio_in[cur]   = sprio;
               aev_in[cur]    = '0;
               creq_in[cur]   = 1'b0;
               cobs_in[cur]   = 1'b0;
               wt_we          = 1'b1;
               wt_waddr       = cur;
               wt_wdata       = '0;
               rsp_in.slot_id = cur;
               state_in       = pts_pkg::SEQ_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pts_pkg::SEQ_DONE: begin
            if (req_ff.action != pts_pkg::ACT_TICK &&
                req_ff.action != pts_pkg::ACT_SPAWN && !rsp_valid_ff) begin
               unique case (req_ff.action)
                  pts_pkg::ACT_WAIT_DELAY: begin
                     if (used_ff[rid]) begin
                        if (creq_ff[rid]) begin
                           cobs_in[rid] = 1'b1;
                        end else begin
                           tstate_in[rid] = pts_pkg::ST_WAIT_DELAY;
                           wt_we          = 1'b1;
                        end
                     end
                  end
                  pts_pkg::ACT_WAIT_EVENT: begin
                     if (used_ff[rid]) begin
                        if (creq_ff[rid]) begin
                           cobs_in[rid] = 1'b1;
                        end else begin
                           tstate_in[rid] = pts_pkg::ST_WAIT_EVENT;
                           aev_in[rid]    = req_ff.event_id;
                        end
                     end
                  end
                  pts_pkg::ACT_YIELD: begin
                     if (used_ff[rid]) tstate_in[rid] = pts_pkg::ST_READY;
                  end
                  pts_pkg::ACT_FINISH: begin
                     if (used_ff[rid]) tstate_in[rid] = pts_pkg::ST_DONE;
                  end
                  pts_pkg::ACT_CANCEL: begin
                     if (used_ff[rid]) creq_in[rid] = 1'b1;
                  end
                  default: begin
                     evp_in[req_ff.event_id] = 1'b1;
                  end
               endcase
            end
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = pts_pkg::SEQ_IDLE;
            end
         end
         default: state_in = pts_pkg::SEQ_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == pts_pkg::SEQ_IDLE && !rsp_valid_ff)
      else $error("ready outside idle");
   a_chosen_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.chosen_valid |-> rsp_ff.keep_running)
      else $error("chosen without keep_running");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("two items in flight");
   a_cancel_chosen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cancel_seen |-> rsp_ff.chosen_valid)
      else $error("cancel_seen without choice");
endmodule
